/* sv/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and helpers for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	localparam int XY_W  = 38;  // CORDIC vector width
	localparam int Z_W   = 20;  // angle accumulator, 2^-16 rad
	localparam int SUM_W = 36;  // sine and cosine terms, 2^-28 units
	localparam int SP_W  = 29;  // in-range pitch sine
	localparam int RAD_W = 57;  // sqrt radicand
	localparam int R_W   = 58;  // sqrt partial root
	localparam int SQ_N  = 29;  // sqrt steps, one result bit each
	localparam int OUT_W = 17;  // rounded angle before clamping

	localparam logic signed [Z_W-1:0]   PI_Q16      = 20'sd205887;
	localparam logic signed [OUT_W-1:0] PI_Q13      = 17'sd25736;
	localparam logic signed [OUT_W-1:0] HALF_PI_Q13 = 17'sd12868;
	localparam logic signed [SUM_W-1:0] ONE_Q28     = 36'sd268435456;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} vec_t;

	typedef struct packed {
		logic [RAD_W-1:0] v;
		logic [R_W-1:0]   r;
	} sq_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sr;
		logic signed [SUM_W-1:0] cr;
		logic signed [SUM_W-1:0] sy;
		logic signed [SUM_W-1:0] cy;
		logic signed [SP_W-1:0]  sp;
		logic                    clamped;
		logic                    neg;
	} side_t;

	typedef struct packed {
		logic clamped;
		logic neg;
		logic zero_r;
		logic zero_p;
		logic zero_y;
	} flags_t;

	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] a;
		unique case (i)
			0:       a = 20'sd51472;
			1:       a = 20'sd30386;
			2:       a = 20'sd16055;
			3:       a = 20'sd8150;
			4:       a = 20'sd4091;
			5:       a = 20'sd2047;
			6:       a = 20'sd1024;
			7:       a = 20'sd512;
			8:       a = 20'sd256;
			9:       a = 20'sd128;
			10:      a = 20'sd64;
			11:      a = 20'sd32;
			12:      a = 20'sd16;
			13:      a = 20'sd8;
			14:      a = 20'sd4;
			15:      a = 20'sd2;
			16:      a = 20'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// fold the left half plane onto the right one
	function automatic vec_t prep(input logic signed [XY_W-1:0] y,
			input logic signed [XY_W-1:0] x);
		vec_t v;
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.z = (y >= 0) ? PI_Q16 : -PI_Q16;
		end else begin
			v.x = x;
			v.y = y;
			v.z = '0;
		end
		return v;
	endfunction

	// round half up to Q3.13 and clamp
	function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [Z_W-1:0] z,
			input logic signed [OUT_W-1:0] lim);
		logic signed [Z_W-1:0]   zr;
		logic signed [OUT_W-1:0] s;
		zr = (z + 20'sd4) >>> 3;
		s  = zr[OUT_W-1:0];
		if (s > lim)
			return lim;
		else if (s < -lim)
			return -lim;
		return s;
	endfunction

endpackage

`default_nettype wire

/* sv/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One step of the bit-by-bit integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
	parameter int IDX = 0
) (
	input  wire                   clk,
	input  wire                   en,
	input  wire q2e_pkg::sq_t     d,
	output q2e_pkg::sq_t          q
);

	localparam logic [q2e_pkg::R_W-1:0] BIT =
		q2e_pkg::R_W'(1) << (q2e_pkg::RAD_W - 1 - 2 * IDX);

	logic [q2e_pkg::R_W-1:0] sum;
	q2e_pkg::sq_t            nx;

	always_comb begin
		sum = d.r + BIT;
		if ({1'b0, d.v} >= sum) begin
			nx.v = d.v - sum[q2e_pkg::RAD_W-1:0];
			nx.r = (d.r >> 1) + BIT;
		end else begin
			nx.v = d.v;
			nx.r = d.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

`default_nettype wire

/* sv/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring iteration of CORDIC, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire                   clk,
	input  wire                   en,
	input  wire q2e_pkg::vec_t    d,
	output q2e_pkg::vec_t         q
);

	localparam logic signed [q2e_pkg::Z_W-1:0] ANG = q2e_pkg::atan_q16(STAGE);

	logic signed [q2e_pkg::XY_W-1:0] dx;
	logic signed [q2e_pkg::XY_W-1:0] dy;
	q2e_pkg::vec_t                   nx;

	always_comb begin
		dx = d.y >>> STAGE;
		dy = d.x >>> STAGE;
		if (d.y > 0) begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + ANG;
		end else begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

`default_nettype wire

/* sv/quaternion_to_euler.sv */
// Throughput: one item per cycle; the whole pipeline holds when a result waits.
// Stages: products, sums, radicand, 29 square-root cells, quadrant fold,
// CORDIC_STAGES cells for each of roll, pitch and yaw, output register.
// Reset clears only the valid line; payload registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Converts a Q2.14 quaternion into ZYX roll and yaw in Q3.13 and pitch in Q2.13 radians.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire signed [15:0] q_w,
	input  wire signed [15:0] q_x,
	input  wire signed [15:0] q_y,
	input  wire signed [15:0] q_z,
	output logic              out_valid,
	input  wire               out_ready,
	output logic signed [15:0] roll,
	output logic signed [14:0] pitch,
	output logic signed [15:0] yaw,
	output logic              pitch_clamped
);

	localparam int SQ_N  = q2e_pkg::SQ_N;
	localparam int L     = 5 + SQ_N + CORDIC_STAGES;
	localparam int SUM_W = q2e_pkg::SUM_W;
	localparam int XY_W  = q2e_pkg::XY_W;

	logic en;
	logic [L-1:0] v_q;

	assign en        = !v_q[L-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[L-2:0], in_valid};
	end

	// products
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= q_w * q_x;
			yz_s1 <= q_y * q_z;
			xx_s1 <= q_x * q_x;
			yy_s1 <= q_y * q_y;
			wy_s1 <= q_w * q_y;
			zx_s1 <= q_z * q_x;
			wz_s1 <= q_w * q_z;
			xy_s1 <= q_x * q_y;
			zz_s1 <= q_z * q_z;
		end
	end

	// sine and cosine terms
	logic signed [SUM_W-1:0] sp_full;
	logic                    clamp_c;
	q2e_pkg::side_t          side_s2;

	always_comb begin
		sp_full = (SUM_W'(wy_s1) - SUM_W'(zx_s1)) <<< 1;
		clamp_c = (sp_full >= q2e_pkg::ONE_Q28) || (sp_full <= -q2e_pkg::ONE_Q28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.sr      <= (SUM_W'(wx_s1) + SUM_W'(yz_s1)) <<< 1;
			side_s2.cr      <= q2e_pkg::ONE_Q28 - ((SUM_W'(xx_s1) + SUM_W'(yy_s1)) <<< 1);
			side_s2.sy      <= (SUM_W'(wz_s1) + SUM_W'(xy_s1)) <<< 1;
			side_s2.cy      <= q2e_pkg::ONE_Q28 - ((SUM_W'(yy_s1) + SUM_W'(zz_s1)) <<< 1);
			side_s2.sp      <= clamp_c ? '0 : sp_full[q2e_pkg::SP_W-1:0];
			side_s2.clamped <= clamp_c;
			side_s2.neg     <= sp_full < 0;
		end
	end

	// radicand 2^56 - sp^2
	logic signed [2*q2e_pkg::SP_W-1:0] sp_sq;
	q2e_pkg::sq_t                       sq_s3;
	q2e_pkg::side_t                     side_q [0:SQ_N];

	assign sp_sq = side_s2.sp * side_s2.sp;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.v <= (q2e_pkg::RAD_W'(1) << (q2e_pkg::RAD_W - 1))
				- sp_sq[q2e_pkg::RAD_W-1:0];
			sq_s3.r <= '0;
			side_q[0] <= side_s2;
			for (int k = 1; k <= SQ_N; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	// square root chain
	q2e_pkg::sq_t sq_c [0:SQ_N];
	assign sq_c[0] = sq_s3;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		q2e_sqrt_cell #(.IDX(k)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (sq_c[k]),
			.q   (sq_c[k+1])
		);
	end

	// quadrant fold
	q2e_pkg::side_t sd;
	q2e_pkg::vec_t  r_c [0:CORDIC_STAGES];
	q2e_pkg::vec_t  p_c [0:CORDIC_STAGES];
	q2e_pkg::vec_t  y_c [0:CORDIC_STAGES];
	q2e_pkg::flags_t fl_q [0:CORDIC_STAGES];

	assign sd = side_q[SQ_N];

	always_ff @(posedge clk) begin
		if (en) begin
			r_c[0] <= q2e_pkg::prep(XY_W'(sd.sr), XY_W'(sd.cr));
			y_c[0] <= q2e_pkg::prep(XY_W'(sd.sy), XY_W'(sd.cy));
			p_c[0] <= q2e_pkg::prep(XY_W'(sd.sp),
				XY_W'({1'b0, sq_c[SQ_N].r[q2e_pkg::SP_W-1:0]}));
			fl_q[0].clamped <= sd.clamped;
			fl_q[0].neg     <= sd.neg;
			fl_q[0].zero_r  <= (sd.sr == '0) && (sd.cr == '0);
			fl_q[0].zero_y  <= (sd.sy == '0) && (sd.cy == '0);
			fl_q[0].zero_p  <= (sd.sp == '0) && (sq_c[SQ_N].r == '0);
			for (int k = 1; k <= CORDIC_STAGES; k++)
				fl_q[k] <= fl_q[k-1];
		end
	end

	// CORDIC chains
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		q2e_cordic_cell #(.STAGE(k)) u_roll (
			.clk (clk), .en (en), .d (r_c[k]), .q (r_c[k+1])
		);
		q2e_cordic_cell #(.STAGE(k)) u_pitch (
			.clk (clk), .en (en), .d (p_c[k]), .q (p_c[k+1])
		);
		q2e_cordic_cell #(.STAGE(k)) u_yaw (
			.clk (clk), .en (en), .d (y_c[k]), .q (y_c[k+1])
		);
	end

	// output register
	q2e_pkg::flags_t fo;
	logic signed [q2e_pkg::OUT_W-1:0] roll_c, pitch_c, yaw_c;

	assign fo = fl_q[CORDIC_STAGES];

	always_comb begin
		roll_c = fo.zero_r ? '0
			: q2e_pkg::to_q13(r_c[CORDIC_STAGES].z, q2e_pkg::PI_Q13);
		yaw_c  = fo.zero_y ? '0
			: q2e_pkg::to_q13(y_c[CORDIC_STAGES].z, q2e_pkg::PI_Q13);
		if (fo.clamped)
			pitch_c = fo.neg ? -q2e_pkg::HALF_PI_Q13 : q2e_pkg::HALF_PI_Q13;
		else if (fo.zero_p)
			pitch_c = '0;
		else
			pitch_c = q2e_pkg::to_q13(p_c[CORDIC_STAGES].z, q2e_pkg::HALF_PI_Q13);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll          <= roll_c[15:0];
			pitch         <= pitch_c[14:0];
			yaw           <= yaw_c[15:0];
			pitch_clamped <= fo.clamped;
		end
	end

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_q[0])
		else $error("accepted item missing from valid line");
	a_clamp_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pitch_clamped) |-> (pitch == 15'sd12868 || pitch == -15'sd12868))
		else $error("clamped pitch not at half pi");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll <= 16'sd25736 && roll >= -16'sd25736))
		else $error("roll out of range");
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw <= 16'sd25736 && yaw >= -16'sd25736))
		else $error("yaw out of range");
`endif

endmodule

`default_nettype wire
